@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Each macro expands to one labelled concurrent assertion on the rising edge
// of the given clock, switched off while the given reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/crrc_pkg.sv @@
// ----------------------------------------------------------------------------
// CIGAR reference-to-read coordinate package
// Shared payload types, CIGAR op codes, status codes and walk phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crrc_pkg;

  // CIGAR operation codes (BAM encoding).
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BEFORE_START = 2'd1;
  localparam logic [1:0] ST_PAST_END     = 2'd2;
  localparam logic [1:0] ST_NOT_COVERED  = 2'd3;

  // Running read count: -1 up to the saturation limit.
  typedef logic signed [32:0] rd_t;
  localparam rd_t RD_MAX = 33'sd2147483647;

  // Phases of the coordinate walk.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WALK,
    PH_NEXT,
    PH_AFTER_INS,
    PH_DONE,
    PH_FAIL
  } phase_t;

  // One CIGAR element with the query fields of its alignment.
  typedef struct packed {
    logic               first_element;
    logic               last_element;
    logic [3:0]         op_code;
    logic [27:0]        op_length;
    logic signed [31:0] alignment_start;
    logic signed [31:0] ref_coord;
    logic               tail_side;
    logic               allow_miss;
  } in_item_t;

  // One translated coordinate.
  typedef struct packed {
    logic signed [31:0] read_coord;
    logic               near_deletion;
    logic [1:0]         status;
    logic               fault;
  } out_item_t;

  // Walk outcome handed from the walker to the result stage.
  typedef struct packed {
    logic        fail;
    logic [1:0]  status;
    logic        allow;
    rd_t         read_count;
    logic        near;
    logic        tail;
    logic        found;
    logic [27:0] ins_len;
    logic [31:0] total;
  } fin_t;

endpackage

`default_nettype wire

@@ hw/rtl/crrc_walk.sv @@
// ----------------------------------------------------------------------------
// CIGAR walker
// Holds the per-alignment walk state, advances it by one CIGAR element per
// step and captures the walk outcome when the last element goes through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crrc_walk import crrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  in_item_t           item,
  input  logic signed [32:0] goal_diff,
  output logic               emit,
  output fin_t               fin
);

  function automatic logic eats_ref(input logic [3:0] op);
    return op inside {OP_M, OP_D, OP_N, OP_S, OP_EQ, OP_X};
  endfunction

  function automatic logic eats_read(input logic [3:0] op);
    return op inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
  endfunction

  function automatic logic is_gap(input logic [3:0] op);
    return op inside {OP_D, OP_N};
  endfunction

  // Walk state registers.
  phase_t      phase;
  logic [31:0] goal_offset;
  logic [31:0] ref_count;
  rd_t         read_count;
  logic [27:0] pending_shift;
  logic        pending_consumes_read;
  logic        near_deletion_flag;
  logic [31:0] total_read_length;
  logic [27:0] leading_insert_length;
  logic        leading_insert_found;
  logic        prefix_scan_done;
  logic        latched_tail;
  logic        latched_allow;
  logic [1:0]  error_code;

  // State seen by the current element: a first element starts from fresh state.
  phase_t      e_phase;
  logic [31:0] e_goal;
  logic [31:0] e_ref;
  rd_t         e_rd;
  logic [27:0] e_pshift;
  logic        e_pcr;
  logic        e_near;
  logic [31:0] e_total;
  logic [27:0] e_ins;
  logic        e_found;
  logic        e_scan;
  logic        e_tail;
  logic        e_allow;
  logic [1:0]  e_err;

  // Next values.
  phase_t      phase_mid;
  phase_t      phase_next;
  logic [1:0]  error_code_next;
  logic [1:0]  err_end;
  logic        fail_end;
  logic [31:0] ref_count_next;
  rd_t         read_count_next;
  logic [27:0] pending_shift_next;
  logic        pending_consumes_read_next;
  logic        near_deletion_flag_next;
  logic [31:0] total_read_length_next;
  logic [27:0] leading_insert_length_next;
  logic        leading_insert_found_next;
  logic        prefix_scan_done_next;

  // Element decode and walk arithmetic.
  logic [3:0]  op;
  logic [27:0] len;
  logic        op_ref;
  logic        op_read;
  logic        op_gap;
  logic        op_ins;
  logic        active;
  logic [32:0] sum_ref;
  logic        below_goal;
  logic [31:0] shift;
  logic [31:0] ref_new;
  logic        reached;
  logic        shift_lt_len;
  logic        boundary;
  rd_t         delta;
  rd_t         rd_sum;
  logic [32:0] total_sum;
  fin_t        fin_next;

  assign op      = item.op_code;
  assign len     = item.op_length;
  assign op_ref  = eats_ref(op);
  assign op_read = eats_read(op);
  assign op_gap  = is_gap(op);
  assign op_ins  = (op == OP_I);

  // Select fresh state on the first element of an alignment.
  always_comb begin
    if (item.first_element) begin
      if (goal_diff[32]) begin
        e_phase = PH_FAIL;
        e_err   = ST_BEFORE_START;
      end else if (goal_diff == '0) begin
        e_phase = PH_DONE;
        e_err   = ST_OK;
      end else begin
        e_phase = PH_WALK;
        e_err   = ST_OK;
      end
      e_goal   = goal_diff[31:0];
      e_ref    = '0;
      e_rd     = '0;
      e_pshift = '0;
      e_pcr    = 1'b0;
      e_near   = 1'b0;
      e_total  = '0;
      e_ins    = '0;
      e_found  = 1'b0;
      e_scan   = 1'b0;
      e_tail   = item.tail_side;
      e_allow  = item.allow_miss;
    end else begin
      e_phase  = phase;
      e_err    = error_code;
      e_goal   = goal_offset;
      e_ref    = ref_count;
      e_rd     = read_count;
      e_pshift = pending_shift;
      e_pcr    = pending_consumes_read;
      e_near   = near_deletion_flag;
      e_total  = total_read_length;
      e_ins    = leading_insert_length;
      e_found  = leading_insert_found;
      e_scan   = prefix_scan_done;
      e_tail   = latched_tail;
      e_allow  = latched_allow;
    end
  end

  assign active = (e_phase != PH_IDLE);

  // Reference advance towards the goal offset.
  assign sum_ref      = {1'b0, e_ref} + 33'(len);
  assign below_goal   = (sum_ref < {1'b0, e_goal});
  assign shift        = !op_ref ? '0 : (below_goal ? 32'(len) : (e_goal - e_ref));
  assign ref_new      = e_ref + shift;
  assign reached      = (ref_new == e_goal);
  assign shift_lt_len = (shift < 32'(len));

  // Next phase and status.
  always_comb begin
    phase_mid       = e_phase;
    error_code_next = e_err;
    case (e_phase)
      PH_WALK: begin
        if (reached) begin
          if (shift_lt_len) begin
            phase_mid = PH_DONE;
          end else if (item.last_element) begin
            phase_mid       = PH_FAIL;
            error_code_next = ST_PAST_END;
          end else begin
            phase_mid = PH_NEXT;
          end
        end
      end
      PH_NEXT: begin
        if (!op_ins) begin
          phase_mid = PH_DONE;
        end else if (item.last_element) begin
          phase_mid       = PH_FAIL;
          error_code_next = ST_PAST_END;
        end else begin
          phase_mid = PH_AFTER_INS;
        end
      end
      PH_AFTER_INS: begin
        phase_mid = PH_DONE;
      end
      default: begin
      end
    endcase

    // An alignment that ends with the walk still open is a miss.
    err_end = error_code_next;
    case (phase_mid)
      PH_WALK: begin
        err_end = ST_NOT_COVERED;
      end
      PH_NEXT, PH_AFTER_INS: begin
        err_end = ST_PAST_END;
      end
      default: begin
      end
    endcase
    fail_end = (phase_mid != PH_DONE);

    phase_next = item.last_element ? PH_IDLE : phase_mid;
  end

  // Counters, flags and the walk outcome.
  always_comb begin
    delta                      = '0;
    boundary                   = 1'b0;
    ref_count_next             = e_ref;
    near_deletion_flag_next    = e_near;
    pending_shift_next         = e_pshift;
    pending_consumes_read_next = e_pcr;
    case (e_phase)
      PH_WALK: begin
        ref_count_next = ref_new;
        if (!reached) begin
          if (op_read) begin
            delta = rd_t'(len);
          end
        end else if (shift_lt_len) begin
          near_deletion_flag_next = op_gap;
          if (op_gap) begin
            delta = rd_t'(-1);
          end else if (op_read) begin
            delta = rd_t'(shift);
          end
        end else begin
          pending_shift_next         = shift[27:0];
          pending_consumes_read_next = op_read;
        end
      end
      PH_NEXT: begin
        if (op_ins) begin
          delta = rd_t'(len);
        end else begin
          boundary = 1'b1;
        end
      end
      PH_AFTER_INS: begin
        boundary = 1'b1;
      end
      default: begin
      end
    endcase

    // Walk ended on an element boundary: this element decides the gap flag.
    if (boundary) begin
      near_deletion_flag_next = op_gap;
      if (e_pcr) begin
        delta = op_gap ? (rd_t'(e_pshift) - rd_t'(1)) : rd_t'(e_pshift);
      end else if (op_gap) begin
        delta = rd_t'(-1);
      end
    end

    rd_sum          = e_rd + delta;
    read_count_next = (rd_sum > RD_MAX) ? RD_MAX : rd_sum;

    // Saturating read length.
    total_sum = {1'b0, e_total} + 33'(len);
    if (op_read) begin
      total_read_length_next = total_sum[32] ? '1 : total_sum[31:0];
    end else begin
      total_read_length_next = e_total;
    end

    // Leading insertion search, passing over hard and soft clips.
    leading_insert_length_next = e_ins;
    leading_insert_found_next  = e_found;
    prefix_scan_done_next      = e_scan;
    if (!e_scan) begin
      if (op_ins) begin
        leading_insert_length_next = len;
        leading_insert_found_next  = 1'b1;
        prefix_scan_done_next      = 1'b1;
      end else if (op != OP_H && op != OP_S) begin
        prefix_scan_done_next = 1'b1;
      end
    end

    fin_next.fail       = fail_end;
    fin_next.status     = err_end;
    fin_next.allow      = e_allow;
    fin_next.read_count = read_count_next;
    fin_next.near       = near_deletion_flag_next;
    fin_next.tail       = e_tail;
    fin_next.found      = leading_insert_found_next;
    fin_next.ins_len    = leading_insert_length_next;
    fin_next.total      = total_read_length_next;
  end

  assign emit = step && active && item.last_element;

  // State update; elements outside an open alignment leave it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_IDLE;
      goal_offset           <= '0;
      ref_count             <= '0;
      read_count            <= '0;
      pending_shift         <= '0;
      pending_consumes_read <= 1'b0;
      near_deletion_flag    <= 1'b0;
      total_read_length     <= '0;
      leading_insert_length <= '0;
      leading_insert_found  <= 1'b0;
      prefix_scan_done      <= 1'b0;
      latched_tail          <= 1'b0;
      latched_allow         <= 1'b0;
      error_code            <= ST_OK;
    end else if (step && active) begin
      phase                 <= phase_next;
      goal_offset           <= e_goal;
      ref_count             <= ref_count_next;
      read_count            <= read_count_next;
      pending_shift         <= pending_shift_next;
      pending_consumes_read <= pending_consumes_read_next;
      near_deletion_flag    <= near_deletion_flag_next;
      total_read_length     <= total_read_length_next;
      leading_insert_length <= leading_insert_length_next;
      leading_insert_found  <= leading_insert_found_next;
      prefix_scan_done      <= prefix_scan_done_next;
      latched_tail          <= e_tail;
      latched_allow         <= e_allow;
      error_code            <= error_code_next;
    end
  end

  // Walk outcome register.
  always_ff @(posedge clk) begin
    if (emit) begin
      fin <= fin_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crrc_finish.sv @@
// ----------------------------------------------------------------------------
// CIGAR coordinate result stage
// Applies the tail adjustments to a finished walk and forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crrc_finish import crrc_pkg::*; (
  input  fin_t      fin,
  output out_item_t res
);

  rd_t                rc_near;
  logic signed [33:0] limit;
  logic signed [33:0] ins;
  logic signed [33:0] clip;
  logic signed [33:0] rc_final;

  // Right tail: step over the gap when the position sits next to one.
  assign rc_near = (fin.near && fin.tail)
                 ? ((fin.read_count == RD_MAX) ? RD_MAX : (fin.read_count + rd_t'(1)))
                 : fin.read_count;

  // Left tail: a zero offset moves past a leading insertion, capped at the last base.
  assign limit    = $signed({2'b00, fin.total}) - 34'sd1;
  assign ins      = $signed({6'b000000, fin.ins_len});
  assign clip     = (ins < limit) ? ins : limit;
  assign rc_final = (rc_near == '0 && !fin.tail && fin.found)
                  ? clip : {rc_near[32], rc_near};

  always_comb begin
    res.status = fin.status;
    if (fin.fail) begin
      res.read_coord    = '1;
      res.near_deletion = 1'b0;
      res.fault         = !fin.allow;
    end else begin
      res.read_coord    = rc_final[31:0];
      res.near_deletion = fin.near;
      res.fault         = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cigar_ref_to_read_coordinate.sv @@
// Result path: the last CIGAR element passes the input register, the outcome register and the result register in turn.
// Throughput: one CIGAR element per cycle while no stall backs up from the result side.
// Result stalls back up through the outcome register, then the input register.
// Reset: synchronous and active high; it empties every stage and leaves no
// alignment open, so elements before the next first element give no result.
// ----------------------------------------------------------------------------
// CIGAR reference-to-read coordinate translator
// Input register, walker with outcome register, and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cigar_ref_to_read_coordinate import crrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cigar_valid,
  output logic      cigar_stall,
  input  in_item_t  cigar,
  output logic      coord_valid,
  input  logic      coord_stall,
  output out_item_t coord
);

  logic               in_valid_q;
  in_item_t           in_q;
  logic signed [32:0] in_goal;
  logic               fin_valid;
  logic               fin_adv;
  logic               advance_in;
  logic               step;
  logic               emit;
  fin_t               fin;
  out_item_t          res;

  // Stage handshakes.
  assign fin_adv     = !coord_valid || !coord_stall;
  assign advance_in  = !fin_valid || fin_adv;
  assign step        = in_valid_q && advance_in;
  assign cigar_stall = in_valid_q && !advance_in;

  // Input register; the goal offset is formed on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!cigar_stall) begin
      in_valid_q <= cigar_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cigar_valid && !cigar_stall) begin
      in_q    <= cigar;
      in_goal <= $signed({cigar.ref_coord[31], cigar.ref_coord})
               - $signed({cigar.alignment_start[31], cigar.alignment_start});
    end
  end

  crrc_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_q),
    .goal_diff (in_goal),
    .emit      (emit),
    .fin       (fin)
  );

  // Outcome stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (advance_in) begin
      fin_valid <= emit;
    end
  end

  crrc_finish u_finish (
    .fin (fin),
    .res (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (fin_adv) begin
      coord_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv && fin_valid) begin
      coord <= res;
    end
  end

  // A fault is only ever reported with a failing status.
  `ASSERT_IMP(a_fault_has_status, clk, rst, coord_valid && coord.fault, coord.status != ST_OK)
  // A miss always carries the minus-one coordinate and no gap flag.
  `ASSERT_IMP(a_miss_coord, clk, rst, coord_valid && coord.status != ST_OK, coord.read_coord == '1 && !coord.near_deletion)
  // A finished walk that moves on appears in the result register.
  `ASSERT_NEXT(a_fin_to_out, clk, rst, fin_valid && fin_adv, coord_valid)

endmodule

`default_nettype wire

@@ verif/cigar_ref_to_read_coordinate_test.sv @@
// ----------------------------------------------------------------------------
// Testbench for the CIGAR reference-to-read coordinate translator
// Streams CIGAR elements into the block and checks every translated coordinate
// against a cycle-free predictor of the walk. A short directed part covers the
// special cases; random alignments with random gaps on both sides follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cigar_ref_to_read_coordinate_test import crrc_pkg::*;;

  // Op codes outside the BAM set; they consume neither reference nor read.
  localparam logic [3:0] OP_RESERVED_TOP = 4'd15;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cigar_valid = 1'b0;
  logic      cigar_stall;
  in_item_t  cigar = '0;
  logic      coord_valid;
  logic      coord_stall = 1'b0;
  out_item_t coord;

  cigar_ref_to_read_coordinate dut (
    .clk         (clk),
    .rst         (rst),
    .cigar_valid (cigar_valid),
    .cigar_stall (cigar_stall),
    .cigar       (cigar),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coord       (coord)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared test state.
  out_item_t   pending_coords[$];
  int          mismatch_count = 0;
  int          gap_pct = 18;
  logic signed [31:0] q_start;
  logic signed [31:0] q_coord;
  bit          q_tail;
  bit          q_allow;

  // Predictor state for the alignment currently open.
  phase_t      w_phase = PH_IDLE;
  logic [31:0] w_goal = '0;
  logic [31:0] w_ref = '0;
  longint      w_read = 0;
  logic [31:0] w_shift_pend = '0;
  bit          w_pend_reads = 1'b0;
  bit          w_near = 1'b0;
  logic [31:0] w_total = '0;
  logic [27:0] w_lead_len = '0;
  bit          w_lead_seen = 1'b0;
  bit          w_prefix_done = 1'b0;
  bit          w_tail = 1'b0;
  bit          w_allow = 1'b0;
  logic [1:0]  w_status = ST_OK;

  function automatic bit is_ref_op(input logic [3:0] op);
    return op inside {OP_M, OP_D, OP_N, OP_S, OP_EQ, OP_X};
  endfunction

  function automatic bit is_read_op(input logic [3:0] op);
    return op inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
  endfunction

  function automatic bit is_gap(input logic [3:0] op);
    return op == OP_D || op == OP_N;
  endfunction

  // The read count saturates at the largest positive 32-bit value.
  function automatic void bump_read(input longint amount);
    w_read += amount;
    if (w_read > RD_MAX) w_read = RD_MAX;
  endfunction

  function automatic void set_fail(input logic [1:0] code);
    w_status = code;
    w_phase  = PH_FAIL;
  endfunction

  // The goal fell on an element boundary; op is the element that follows it.
  function automatic void settle_at_boundary(input logic [3:0] op);
    bit gap;
    gap = is_gap(op);
    w_near = gap;
    if (!gap && w_pend_reads) bump_read(longint'(w_shift_pend));
    else if (gap && w_pend_reads) bump_read(longint'(w_shift_pend) - 1);
    else if (gap) w_read -= 1;
    w_phase = PH_DONE;
  endfunction

  // One step of the reference walk, including the look-ahead past an insertion.
  function automatic void advance_walk(input logic [3:0] op, input logic [27:0] len,
                                       input bit last);
    logic [31:0] shift;
    shift = '0;
    case (w_phase)
      PH_WALK: begin
        if (is_ref_op(op)) begin
          if (33'(w_ref) + 33'(len) < 33'(w_goal)) shift = 32'(len);
          else shift = w_goal - w_ref;
          w_ref += shift;
        end
        if (w_ref != w_goal) begin
          if (is_read_op(op)) bump_read(longint'(len));
        end else if (shift < 32'(len)) begin
          w_near = is_gap(op);
          if (!w_near && is_read_op(op)) bump_read(longint'(shift));
          else if (w_near) w_read -= 1;
          w_phase = PH_DONE;
        end else if (last) begin
          set_fail(ST_PAST_END);
        end else begin
          w_shift_pend = shift;
          w_pend_reads = is_read_op(op);
          w_phase      = PH_NEXT;
        end
      end
      PH_NEXT: begin
        if (op == OP_I) begin
          bump_read(longint'(len));
          if (last) set_fail(ST_PAST_END);
          else w_phase = PH_AFTER_INS;
        end else begin
          settle_at_boundary(op);
        end
      end
      PH_AFTER_INS: begin
        settle_at_boundary(op);
      end
      default: begin
      end
    endcase
  endfunction

  // Applies one CIGAR element; returns 1 with the coordinate when one is due.
  function automatic bit predict_coordinate(input in_item_t it, output out_item_t res);
    longint      goal;
    longint      rc;
    longint      lim;
    logic [32:0] sum;
    res = '0;
    if (it.first_element) begin
      goal = longint'($signed(it.ref_coord)) - longint'($signed(it.alignment_start));
      w_goal        = '0;
      w_ref         = '0;
      w_read        = 0;
      w_shift_pend  = '0;
      w_pend_reads  = 1'b0;
      w_near        = 1'b0;
      w_total       = '0;
      w_lead_len    = '0;
      w_lead_seen   = 1'b0;
      w_prefix_done = 1'b0;
      w_status      = ST_OK;
      w_tail        = it.tail_side;
      w_allow       = it.allow_miss;
      if (goal < 0) begin
        set_fail(ST_BEFORE_START);
      end else begin
        w_goal  = goal[31:0];
        w_phase = (goal == 0) ? PH_DONE : PH_WALK;
      end
    end
    if (w_phase == PH_IDLE) return 1'b0;

    // Read length and leading insertion, whatever the walk is doing.
    if (is_read_op(it.op_code)) begin
      sum = 33'(w_total) + 33'(it.op_length);
      w_total = sum[32] ? '1 : sum[31:0];
    end
    if (!w_prefix_done) begin
      if (it.op_code == OP_I) begin
        w_lead_len    = it.op_length;
        w_lead_seen   = 1'b1;
        w_prefix_done = 1'b1;
      end else if (it.op_code != OP_H && it.op_code != OP_S) begin
        w_prefix_done = 1'b1;
      end
    end
    advance_walk(it.op_code, it.op_length, it.last_element);
    if (!it.last_element) return 1'b0;

    if (w_phase == PH_WALK) set_fail(ST_NOT_COVERED);
    else if (w_phase inside {PH_NEXT, PH_AFTER_INS}) set_fail(ST_PAST_END);

    if (w_phase == PH_FAIL) begin
      rc = -1;
      res.fault = !w_allow;
    end else begin
      rc = w_read;
      res.near_deletion = w_near;
      if (w_near && w_tail) begin
        rc++;
        if (rc > RD_MAX) rc = RD_MAX;
      end
      if (rc == 0 && !w_tail && w_lead_seen) begin
        lim = longint'(w_total) - 1;
        rc  = (longint'(w_lead_len) < lim) ? longint'(w_lead_len) : lim;
      end
    end
    res.read_coord = rc[31:0];
    res.status     = w_status;
    w_phase        = PH_IDLE;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Query fields travel only on the first element; later ones carry noise there.
  function automatic in_item_t cigar_element(input bit first, input bit last,
                                             input logic [3:0] op, input logic [27:0] len);
    in_item_t it;
    it.first_element = first;
    it.last_element  = last;
    it.op_code       = op;
    it.op_length     = len;
    if (first) begin
      it.alignment_start = q_start;
      it.ref_coord       = q_coord;
      it.tail_side       = q_tail;
      it.allow_miss      = q_allow;
    end else begin
      it.alignment_start = $urandom;
      it.ref_coord       = $urandom;
      it.tail_side       = 1'($urandom_range(1));
      it.allow_miss      = 1'($urandom_range(1));
    end
    return it;
  endfunction

  task automatic set_query(input logic signed [31:0] start, input longint goal,
                           input bit tail, input bit allow);
    q_start = start;
    q_coord = 32'(longint'(start) + goal);
    q_tail  = tail;
    q_allow = allow;
  endtask

  // Sends one element, with a random gap first, and records the coordinate it causes.
  task automatic send_element(input in_item_t item);
    out_item_t res;
    while ($urandom_range(99) < gap_pct) begin
      cigar_valid <= 1'b0;
      @(posedge clk);
    end
    cigar       <= item;
    cigar_valid <= 1'b1;
    @(posedge clk);
    while (cigar_stall) @(posedge clk);
    if (predict_coordinate(item, res)) pending_coords.push_back(res);
  endtask

  // Result side: random stalls, and each transfer checked against the oldest prediction.
  always @(posedge clk) begin : check_coordinates
    out_item_t want;
    if (!rst && coord_valid === 1'b1 && !coord_stall) begin
      if (pending_coords.size() == 0) begin
        report_mismatch($sformatf("unexpected result, read_coord %0d status %0d",
                                  coord.read_coord, coord.status));
      end else begin
        want = pending_coords.pop_front();
        if (coord.read_coord !== want.read_coord)
          report_mismatch($sformatf("read_coord %0d, expected %0d",
                                    coord.read_coord, want.read_coord));
        if (coord.near_deletion !== want.near_deletion)
          report_mismatch($sformatf("near_deletion %0b, expected %0b",
                                    coord.near_deletion, want.near_deletion));
        if (coord.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", coord.status, want.status));
        if (coord.fault !== want.fault)
          report_mismatch($sformatf("fault %0b, expected %0b", coord.fault, want.fault));
      end
    end
    coord_stall <= ($urandom_range(99) < gap_pct);
  end

  // Elements arriving with no alignment open must be dropped silently.
  task automatic test_ignored_elements();
    set_query(0, 5, 1'b0, 1'b0);
    send_element(cigar_element(1'b0, 1'b1, OP_M, 28'd9));
  endtask

  task automatic test_zero_goal();
    set_query(12345, 0, 1'b1, 1'b0);
    send_element(cigar_element(1'b1, 1'b1, OP_M, 28'd7));
  endtask

  // Left tail with a read that opens with an insertion after hard and soft clips.
  task automatic test_leading_insertion();
    set_query(-40, 0, 1'b0, 1'b0);
    send_element(cigar_element(1'b1, 1'b0, OP_H, 28'd2));
    send_element(cigar_element(1'b0, 1'b0, OP_S, 28'd3));
    send_element(cigar_element(1'b0, 1'b0, OP_I, 28'd4));
    send_element(cigar_element(1'b0, 1'b1, OP_M, 28'd10));
    // An empty insertion alone leaves no room in the read at all.
    set_query(8, 0, 1'b0, 1'b1);
    send_element(cigar_element(1'b1, 1'b1, OP_I, 28'd0));
  endtask

  // Goal inside a deletion, then inside a leading deletion (negative alignment start).
  task automatic test_inside_gap();
    set_query(100, 3, 1'b1, 1'b0);
    send_element(cigar_element(1'b1, 1'b0, OP_M, 28'd2));
    send_element(cigar_element(1'b0, 1'b1, OP_D, 28'd4));
    set_query(-1, 1, 1'b0, 1'b0);
    send_element(cigar_element(1'b1, 1'b1, OP_D, 28'd3));
  endtask

  // Goal on a boundary followed by an insertion and then a skip.
  task automatic test_boundary_lookahead();
    set_query(50, 2, 1'b1, 1'b0);
    send_element(cigar_element(1'b1, 1'b0, OP_M, 28'd2));
    send_element(cigar_element(1'b0, 1'b0, OP_I, 28'd3));
    send_element(cigar_element(1'b0, 1'b1, OP_N, 28'd5));
  endtask

  task automatic test_walk_failures();
    // Goal before the start, at the extremes of both coordinates.
    set_query(32'sh7fff_ffff, -64'sd4294967295, 1'b0, 1'b0);
    send_element(cigar_element(1'b1, 1'b1, OP_M, 28'd5));
    // Goal on the very end of the CIGAR.
    set_query(0, 2, 1'b0, 1'b1);
    send_element(cigar_element(1'b1, 1'b1, OP_M, 28'd2));
    // Goal on a boundary with only an insertion after it.
    set_query(7, 2, 1'b1, 1'b0);
    send_element(cigar_element(1'b1, 1'b0, OP_M, 28'd2));
    send_element(cigar_element(1'b0, 1'b1, OP_I, 28'd1));
    // Goal beyond everything the CIGAR covers.
    set_query(-9, 50, 1'b0, 1'b0);
    send_element(cigar_element(1'b1, 1'b1, OP_M, 28'd5));
  endtask

  task automatic test_unusual_ops();
    set_query(-5, 3, 1'b0, 1'b1);
    send_element(cigar_element(1'b1, 1'b0, OP_RESERVED_TOP, 28'd9));
    send_element(cigar_element(1'b0, 1'b0, OP_P, 28'd2));
    send_element(cigar_element(1'b0, 1'b0, OP_EQ, 28'd1));
    send_element(cigar_element(1'b0, 1'b1, OP_X, 28'd5));
  endtask

  // Maximal insertions bring the read count close to saturation; the boundary at the closing deletion saturates it.
  task automatic test_count_saturation();
    set_query(32'sh8000_0000, 10, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++)
      send_element(cigar_element(i == 0, 1'b0, OP_I, '1));
    send_element(cigar_element(1'b0, 1'b0, OP_M, 28'd10));
    send_element(cigar_element(1'b0, 1'b1, OP_D, 28'd1));
  endtask

  // Random well-formed alignments, with some stray and truncated ones mixed in.
  task automatic test_random_alignments(input int quota);
    logic [3:0]  ops [10];
    logic [27:0] lens [10];
    longint      reach [10];
    longint      span;
    longint      goal;
    int          n_ops;
    int          sent;
    int          pick;
    bit          broken;
    sent = 0;
    while (sent < quota) begin
      n_ops = $urandom_range(8, 1);
      span  = 0;
      for (int i = 0; i < n_ops; i++) begin
        pick = $urandom_range(99);
        if (pick < 35) ops[i] = OP_M;
        else if (pick < 47) ops[i] = OP_I;
        else if (pick < 56) ops[i] = OP_D;
        else if (pick < 62) ops[i] = OP_N;
        else if (pick < 69) ops[i] = OP_S;
        else if (pick < 74) ops[i] = OP_H;
        else if (pick < 78) ops[i] = OP_P;
        else if (pick < 84) ops[i] = OP_EQ;
        else if (pick < 93) ops[i] = OP_X;
        else ops[i] = 4'($urandom_range(OP_RESERVED_TOP, OP_X + 1));
        pick = $urandom_range(99);
        if (pick < 5) lens[i] = '0;
        else if (pick < 93) lens[i] = 28'($urandom_range(12, 1));
        else if (pick < 98) lens[i] = 28'($urandom_range(1000, 13));
        else lens[i] = 28'($urandom);
      end
      // Favour reads that open with clips and an insertion.
      pick = $urandom_range(99);
      if (pick < 15) begin
        ops[0] = OP_I;
      end else if (pick < 25 && n_ops > 1) begin
        ops[0] = ($urandom_range(1) != 0) ? OP_S : OP_H;
        ops[1] = OP_I;
      end
      for (int i = 0; i < n_ops; i++) begin
        if (is_ref_op(ops[i])) span += lens[i];
        reach[i] = span;
      end

      pick = $urandom_range(99);
      if (pick < 8) goal = 0;
      else if (pick < 13) goal = -longint'($urandom_range(1000, 1));
      else if (pick < 18) goal = span + longint'($urandom_range(4, 1));
      else if (pick < 45) goal = reach[$urandom_range(n_ops - 1)] + longint'($urandom_range(1));
      else goal = longint'($urandom_range(32'(span) + 1, 1));

      if ($urandom_range(19) == 0) begin
        set_query($urandom, goal, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        set_query($urandom_range(2000000) - 1000000, goal, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 3) q_coord = $urandom;

      // A stray element between alignments, then the alignment, sometimes cut short.
      if ($urandom_range(99) < 5)
        send_element(cigar_element(1'b0, 1'($urandom_range(1)), 4'($urandom),
                                   28'($urandom)));
      broken = ($urandom_range(99) < 6);
      for (int i = 0; i < n_ops; i++)
        send_element(cigar_element(i == 0, (i == n_ops - 1) && !broken, ops[i], lens[i]));
      sent += n_ops;
    end
  endtask

  // A long stretch with neither side pausing.
  task automatic test_back_to_back();
    gap_pct = 0;
    test_random_alignments(300);
    gap_pct = 18;
  endtask

  initial begin : run_tests
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_ignored_elements();
    test_zero_goal();
    test_leading_insertion();
    test_inside_gap();
    test_boundary_lookahead();
    test_walk_failures();
    test_unusual_ops();
    test_count_saturation();
    test_random_alignments(1700);
    test_back_to_back();
    cigar_valid <= 1'b0;

    // Let the last results drain, then keep watching for any unexpected result.
    waited = 0;
    while (pending_coords.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_coords.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_coords.size()));

    if (mismatch_count == 0) begin
      $display("cigar_ref_to_read_coordinate test passed");
    end else begin
      $display("cigar_ref_to_read_coordinate test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("cigar_ref_to_read_coordinate test failed");
    $finish;
  end

endmodule
